// ===== hdl/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== hdl/erv_pkg.sv =====
package erv_pkg;

  localparam int PIPE_DEPTH = 11;
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [31:0] vec_t;
  typedef logic [15:0] angle_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } in_word_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
  } out_word_t;

  localparam logic signed [31:0] COEF0 = 32'sd3864;
  localparam logic signed [31:0] COEF1 = 32'sd172272;
  localparam logic signed [31:0] COEF2 = 32'sd5026995;
  localparam logic signed [31:0] COEF3 = 32'sd85569306;
  localparam logic signed [31:0] COEF4 = 32'sd693598668;
  localparam logic signed [31:0] COEF5 = 32'sd1686629713;

  function automatic logic signed [31:0] coef(input int i);
    case (i)
      0: coef = COEF0;
      1: coef = COEF1;
      2: coef = COEF2;
      3: coef = COEF3;
      4: coef = COEF4;
      default: coef = COEF5;
    endcase
  endfunction

  // Q30 product, rounded half away from zero
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    logic [63:0] mag;
    logic [63:0] q;
    p = 64'(a) * 64'(b);
    mag = p[63] ? 64'(-p) : 64'(p);
    q = (mag + 64'd536870912) >> 30;
    qmul = p[63] ? 32'(-q) : 32'(q);
  endfunction

  function automatic q30_t clamp_unit(input logic signed [32:0] m);
    if (m > 33'sd1073741824) clamp_unit = Q30_ONE;
    else if (m < -33'sd1073741824) clamp_unit = -Q30_ONE;
    else clamp_unit = 32'(m);
  endfunction

endpackage

// ===== hdl/erv_if.sv =====
interface erv_in_if (input logic clk);
  logic valid;
  logic ready;
  erv_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface erv_out_if (input logic clk);
  logic valid;
  logic ready;
  erv_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/erv_sine_lane.sv =====
module erv_sine_lane (
  input  logic clk,
  input  logic en,
  input  erv_pkg::angle_t angle,
  output erv_pkg::q30_t sin_val,
  output erv_pkg::q30_t cos_val
);
  // stage 0: quadrant split, z and z^2 (two products: one per wave)
  logic [1:0] qs0, qc0;
  logic signed [31:0] zs0, zc0;
  logic signed [31:0] z2s0, z2c0;
  logic [1:0] qs [0:5];
  logic [1:0] qc [0:5];
  logic signed [31:0] zs [0:5];
  logic signed [31:0] zc [0:5];
  logic signed [31:0] z2s [0:5];
  logic signed [31:0] z2c [0:5];
  logic signed [31:0] ps [0:5];
  logic signed [31:0] pc [0:5];
  logic [15:0] acos;
  logic [14:0] rs, rc;
  logic signed [63:0] zzs, zzc;

  always_comb begin
    acos = angle + 16'd16384;
    rs = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    rc = acos[14] ? 15'(15'd16384 - {1'b0, acos[13:0]}) : {1'b0, acos[13:0]};
    zs0 = 32'({rs, 16'd0});
    zc0 = 32'({rc, 16'd0});
    zzs = 64'(zs0) * 64'(zs0);
    zzc = 64'(zc0) * 64'(zc0);
    z2s0 = 32'(zzs >>> 30);
    z2c0 = 32'(zzc >>> 30);
    qs0 = angle[15:14];
    qc0 = acos[15:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs[0] <= qs0; qc[0] <= qc0;
      zs[0] <= zs0; zc[0] <= zc0;
      z2s[0] <= z2s0; z2c[0] <= z2c0;
      ps[0] <= erv_pkg::COEF0; pc[0] <= erv_pkg::COEF0;
    end
  end

  for (genvar i = 1; i < 6; i++) begin : g_horner
    logic signed [63:0] ms, mc;
    assign ms = 64'(z2s[i-1]) * 64'(ps[i-1]);
    assign mc = 64'(z2c[i-1]) * 64'(pc[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        qs[i] <= qs[i-1]; qc[i] <= qc[i-1];
        zs[i] <= zs[i-1]; zc[i] <= zc[i-1];
        z2s[i] <= z2s[i-1]; z2c[i] <= z2c[i-1];
        ps[i] <= 32'(64'(erv_pkg::coef(i)) - (ms >>> 30));
        pc[i] <= 32'(64'(erv_pkg::coef(i)) - (mc >>> 30));
      end
    end
  end

  logic signed [63:0] fs, fc, fs_sh, fc_sh;
  logic signed [31:0] ss, sc;
  assign fs = 64'(zs[5]) * 64'(ps[5]);
  assign fc = 64'(zc[5]) * 64'(pc[5]);
  assign fs_sh = fs >>> 30;
  assign fc_sh = fc >>> 30;
  always_comb begin
    if (fs_sh > 64'sd1073741824) ss = erv_pkg::Q30_ONE;
    else if (fs_sh < 0) ss = '0;
    else ss = 32'(fs_sh);
    if (fc_sh > 64'sd1073741824) sc = erv_pkg::Q30_ONE;
    else if (fc_sh < 0) sc = '0;
    else sc = 32'(fc_sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= qs[5][1] ? -ss : ss;
      cos_val <= qc[5][1] ? -sc : sc;
    end
  end

  logic unused;
  assign unused = ^{z2s[5], z2c[5], qs[5][0], qc[5][0]};
endmodule

// ===== hdl/erv_merge.sv =====
module erv_merge (
  input  logic clk,
  input  logic en,
  input  erv_pkg::q30_t s1, c1, s2, c2, s3, c3,
  input  erv_pkg::vec_t vx, vy, vz,
  output erv_pkg::out_word_t res
);
  erv_pkg::q30_t a_s1, a_c1, a_s2, a_c2, a_s3, a_c3, s1s2, c1s2;
  erv_pkg::vec_t x1, y1, z1, x2, y2, z2;
  erv_pkg::q30_t m [0:8];
  logic signed [63:0] pr [0:8];

  function automatic erv_pkg::vec_t row(input logic signed [63:0] a, b, c);
    logic signed [65:0] acc;
    logic [65:0] mag, q;
    logic signed [66:0] r;
    acc = 66'(a) + 66'(b) + 66'(c);
    mag = acc[65] ? 66'(-acc) : 66'(acc);
    q = (mag + 66'd536870912) >> 30;
    r = acc[65] ? -67'(q) : 67'(q);
    if (r > 67'sd2147483647) row = 32'sh7fffffff;
    else if (r < -67'sd2147483648) row = 32'sh80000000;
    else row = 32'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_s1 <= s1; a_c1 <= c1; a_s2 <= s2; a_c2 <= c2; a_s3 <= s3; a_c3 <= c3;
      s1s2 <= erv_pkg::qmul(s1, s2);
      c1s2 <= erv_pkg::qmul(c1, s2);
      x1 <= vx; y1 <= vy; z1 <= vz;
      m[0] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_c2, a_c3)));
      m[1] <= erv_pkg::clamp_unit(-33'(erv_pkg::qmul(a_c2, a_s3)));
      m[2] <= erv_pkg::clamp_unit(33'(a_s2));
      m[3] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_c1, a_s3))
              + 33'(erv_pkg::qmul(s1s2, a_c3)));
      m[4] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_c1, a_c3))
              - 33'(erv_pkg::qmul(s1s2, a_s3)));
      m[5] <= erv_pkg::clamp_unit(-33'(erv_pkg::qmul(a_s1, a_c2)));
      m[6] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_s1, a_s3))
              - 33'(erv_pkg::qmul(c1s2, a_c3)));
      m[7] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_s1, a_c3))
              + 33'(erv_pkg::qmul(c1s2, a_s3)));
      m[8] <= erv_pkg::clamp_unit(33'(erv_pkg::qmul(a_c1, a_c2)));
      x2 <= x1; y2 <= y1; z2 <= z1;
      pr[0] <= 64'(m[0]) * 64'(x2); pr[1] <= 64'(m[1]) * 64'(y2);
      pr[2] <= 64'(m[2]) * 64'(z2); pr[3] <= 64'(m[3]) * 64'(x2);
      pr[4] <= 64'(m[4]) * 64'(y2); pr[5] <= 64'(m[5]) * 64'(z2);
      pr[6] <= 64'(m[6]) * 64'(x2); pr[7] <= 64'(m[7]) * 64'(y2);
      pr[8] <= 64'(m[8]) * 64'(z2);
      res.x <= row(pr[0], pr[1], pr[2]);
      res.y <= row(pr[3], pr[4], pr[5]);
      res.z <= row(pr[6], pr[7], pr[8]);
    end
  end
endmodule

// ===== hdl/euler_rotate_vector_core.sv =====
// channel | dir | word
// in      | in  | vec_x/y/z Q15.16, angle_roll/pitch/yaw binary angle
// out     | out | rot_x/y/z Q15.16 saturated
// One word per cycle while the output is not stalled; the valid shift line is PIPE_DEPTH deep.
// Seven stages per sine lane (split, five Horner steps, fold), four in the merge.
// Synchronous reset clears the valid shift line only.
// A stalled output freezes the whole pipeline; input ready follows output room.
`include "assert_macros.svh"
module euler_rotate_vector_core (
  input logic clk,
  input logic rst,
  erv_in_if.sink in,
  erv_out_if.source out
);
  logic en;
  logic [erv_pkg::PIPE_DEPTH-1:0] vld;
  erv_pkg::q30_t s1, c1, s2, c2, s3, c3;

  assign en = !vld[erv_pkg::PIPE_DEPTH-1] || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[erv_pkg::PIPE_DEPTH-2:0], in.valid};
    end
  end

  erv_pkg::vec_t dx [0:6];
  erv_pkg::vec_t dy [0:6];
  erv_pkg::vec_t dz [0:6];
  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= in.data.x; dy[0] <= in.data.y; dz[0] <= in.data.z;
      for (int i = 1; i < 7; i++) begin
        dx[i] <= dx[i-1]; dy[i] <= dy[i-1]; dz[i] <= dz[i-1];
      end
    end
  end

  erv_sine_lane u_roll (.clk, .en, .angle(in.data.roll), .sin_val(s1), .cos_val(c1));
  erv_sine_lane u_pitch (.clk, .en, .angle(in.data.pitch), .sin_val(s2), .cos_val(c2));
  erv_sine_lane u_yaw (.clk, .en, .angle(in.data.yaw), .sin_val(s3), .cos_val(c3));

  erv_merge u_merge (
    .clk, .en, .s1, .c1, .s2, .c2, .s3, .c3,
    .vx(dx[6]), .vy(dy[6]), .vz(dz[6]), .res(out.data)
  );

  assign out.valid = vld[erv_pkg::PIPE_DEPTH-1];

  `ASSERT_IMPL(a_ready, clk, rst, !out.valid, in.ready, "ready low with empty output")
  `ASSERT_NEXT(a_hold, clk, rst, out.valid && !out.ready, out.valid, "result dropped")
endmodule
